@@ hw/rtl/triangle_near_plane_clip_core_assert.svh @@
// Assertion macros for the near-plane clipper
`ifndef TRIANGLE_NEAR_PLANE_CLIP_CORE_ASSERT_SVH
`define TRIANGLE_NEAR_PLANE_CLIP_CORE_ASSERT_SVH
`define TNPC_ASSERT_IMP(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
else $error("assertion failed");
`define TNPC_ASSERT_NXT(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
else $error("assertion failed");
`endif

@@ hw/rtl/tnpc_pkg.sv @@
// Package with the shared constants for the near-plane clipper
`default_nettype none
package tnpc_pkg;
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS = 16;
endpackage
`default_nettype wire

@@ hw/rtl/tnpc_div.sv @@
// Pipelined fraction divider: q = floor(num * 2^FRAC / den), num < den
`default_nettype none
module tnpc_div #(
    parameter int W = 33,
    parameter int F = 16
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic [F-1:0]      q
);
    logic [W:0]   rem_reg [F+1];
    logic [W-1:0] den_reg [F+1];
    logic [F-1:0] q_reg   [F+1];
    always_comb
    begin
        rem_reg[0] = {1'b0, num};
        den_reg[0] = den;
        q_reg[0] = '0;
    end
    for (genvar i = 0; i < F; i++) begin : g_st
        logic [W:0] sh;
        logic       ge;
        always_comb
        begin
            sh = {rem_reg[i][W-1:0], 1'b0};
            ge = sh >= {1'b0, den_reg[i]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? sh - {1'b0, den_reg[i]} : sh;
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1] <= {q_reg[i][F-2:0], ge};
            end
        end
    end
    assign q = q_reg[F];
endmodule
`default_nettype wire

@@ hw/rtl/tnpc_blend.sv @@
// Registered blend: p + floor((q - p) * t / 2^F)
`default_nettype none
module tnpc_blend #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic signed [W-1:0] p,
    input  wire logic signed [W-1:0] q,
    input  wire logic [F-1:0]        t,
    output logic signed [W-1:0]      r
);
    logic signed [W:0]     d_reg;
    logic signed [W-1:0]   p_reg, p2_reg;
    logic [F-1:0]          t_reg;
    logic signed [W+F+1:0] m_reg;
    logic signed [W+F+1:0] m_sh;
    always_comb m_sh = m_reg >>> F;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= {q[W-1], q} - {p[W-1], p};
            p_reg <= p;
            t_reg <= t;
            m_reg <= d_reg * $signed({1'b0, t_reg});
            p2_reg <= p_reg;
            r <= W'(p2_reg + m_sh[W-1:0]);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/triangle_near_plane_clip_core.sv @@
// Top level: near-plane triangle clipper
// Usage:
//  Input channel in_valid/in_ready takes one triangle (a, b, c) per request.
//  Output channel out_valid/out_ready gives zero, one or two triangles per
//  request, last_of_run marking the final one. cfg_valid/cfg_ready writes
//  near_z; write only while idle.
//  Every request flows through 21 register stages (classify, 16 divider
//  stages, 3 blend stages, output register).
//  A request yielding two triangles stalls the pipeline while its first
//  triangle is loaded and lets it move again as the second is loaded:
//  throughput is one triangle per cycle on the output while out_ready holds.
//  When the receiver stalls the whole pipeline holds; nothing is lost.
//  Reset clears valid bits and sets near_z to 0.
`default_nettype none
module triangle_near_plane_clip_core #(
    parameter int COORD_BITS = tnpc_pkg::COORD_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic signed [COORD_BITS-1:0] p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
    output logic      last_of_run
);
    localparam int W = COORD_BITS;
    localparam int F = tnpc_pkg::FRAC_BITS;
    localparam int D = F + 4;
    typedef logic signed [W-1:0] crd_t;
    typedef struct packed { crd_t x, y, z; } vtx_t;
    typedef struct packed { logic [1:0] n; vtx_t i0, i1, o0, o1; } cls_t;

    logic signed [W-1:0] near_z_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) near_z_reg <= '0;
        else if (cfg_valid) near_z_reg <= W'(cfg_data);
    end

    // output stage with second-triangle state
    logic second_reg;
    logic en;
    logic [D-1:0] v_reg;
    cls_t c_reg [D];
    vtx_t e0, e1;

    // classification
    vtx_t va, vb, vc;
    logic ia, ib, ic;
    cls_t cn;
    always_comb
    begin
        va = '{a_x, a_y, a_z};
        vb = '{b_x, b_y, b_z};
        vc = '{c_x, c_y, c_z};
        ia = a_z >= near_z_reg;
        ib = b_z >= near_z_reg;
        ic = c_z >= near_z_reg;
        cn.n = 2'(ia) + 2'(ib) + 2'(ic);
        cn.i0 = ia ? va : (ib ? vb : vc);
        cn.i1 = (ia && ib) ? vb : vc;
        cn.o0 = !ia ? va : (!ib ? vb : vc);
        cn.o1 = (!ia && !ib) ? vb : vc;
        if (ia && ib && ic) cn.o0 = vc;
    end

    logic hold;
    logic out_busy;
    logic need2;
    assign out_busy = out_valid && !out_ready;
    assign need2 = v_reg[D-1] && c_reg[D-1].n == 2'd2 && !second_reg;
    assign hold = out_busy || need2;
    assign en = !hold;
    assign in_ready = en;

    logic signed [W:0] nz0, nz1;
    logic [F-1:0] t0, t1;
    // divider 0: edge i0->o0, divider 1: i0->o1 (one inside) or i1->o0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= cn;
            nz0 <= {cn.i0.z[W-1], cn.i0.z} - {near_z_reg[W-1], near_z_reg};
            nz1 <= (cn.n == 2'd1)
                ? {cn.i0.z[W-1], cn.i0.z} - {near_z_reg[W-1], near_z_reg}
                : {cn.i1.z[W-1], cn.i1.z} - {near_z_reg[W-1], near_z_reg};
        end
    end
    vtx_t a1, b1;
    assign a1 = (c_reg[0].n == 2'd1) ? c_reg[0].i0 : c_reg[0].i1;
    assign b1 = (c_reg[0].n == 2'd1) ? c_reg[0].o1 : c_reg[0].o0;
    logic signed [W:0] dz0, dz1;
    assign dz0 = {c_reg[0].i0.z[W-1], c_reg[0].i0.z} - {c_reg[0].o0.z[W-1], c_reg[0].o0.z};
    assign dz1 = {a1.z[W-1], a1.z} - {b1.z[W-1], b1.z};

    tnpc_div #(.W(W+1), .F(F)) u_div0 (.clk, .en, .num(nz0), .den(dz0), .q(t0));
    tnpc_div #(.W(W+1), .F(F)) u_div1 (.clk, .en, .num(nz1), .den(dz1), .q(t1));

    for (genvar s = 1; s < D; s++) begin : g_c
        always_ff @(posedge clk)
            if (en) c_reg[s] <= c_reg[s-1];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else if (en) v_reg <= {v_reg[D-2:0], in_valid};
    end

    // blend inputs taken at stage F (divider output aligned)
    cls_t cb;
    vtx_t bp1, bq1;
    assign cb = c_reg[F];
    assign bp1 = (cb.n == 2'd1) ? cb.i0 : cb.i1;
    assign bq1 = (cb.n == 2'd1) ? cb.o1 : cb.o0;
    tnpc_blend #(.W(W), .F(F)) u_b0x (.clk, .en, .p(cb.i0.x), .q(cb.o0.x), .t(t0), .r(e0.x));
    tnpc_blend #(.W(W), .F(F)) u_b0y (.clk, .en, .p(cb.i0.y), .q(cb.o0.y), .t(t0), .r(e0.y));
    tnpc_blend #(.W(W), .F(F)) u_b0z (.clk, .en, .p(cb.i0.z), .q(cb.o0.z), .t(t0), .r(e0.z));
    tnpc_blend #(.W(W), .F(F)) u_b1x (.clk, .en, .p(bp1.x), .q(bq1.x), .t(t1), .r(e1.x));
    tnpc_blend #(.W(W), .F(F)) u_b1y (.clk, .en, .p(bp1.y), .q(bq1.y), .t(t1), .r(e1.y));
    tnpc_blend #(.W(W), .F(F)) u_b1z (.clk, .en, .p(bp1.z), .q(bq1.z), .t(t1), .r(e1.z));

    // output register; stage D-1 holds the item whose edges are e0/e1
    cls_t co;
    vtx_t tp, tq, tr;
    logic tl, tv;
    logic ld;
    assign co = c_reg[D-1];
    always_comb
    begin
        tp = co.i0; tq = co.i1; tr = co.o0; tl = 1'b1;
        tv = v_reg[D-1] && co.n != 2'd0;
        unique case (co.n)
            2'd1: begin tq = e0; tr = e1; end
            2'd2:
            begin
                if (!second_reg) begin tr = e0; tl = 1'b0; end
                else begin tp = co.i1; tq = e1; tr = e0; end
            end
            default: ;
        endcase
    end
    assign ld = !out_busy;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (ld)
        begin
            out_valid <= tv;
            second_reg <= need2;
        end
    end
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            {p_x, p_y, p_z} <= tp;
            {q_x, q_y, q_z} <= tq;
            {r_x, r_y, r_z} <= tr;
            last_of_run <= tl;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/tnpc_checker.sv @@
// Port checker for the near-plane clipper
`default_nettype none
`include "triangle_near_plane_clip_core_assert.svh"
module tnpc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic in_ready,
    input wire logic last_of_run,
    input wire logic cfg_ready
);
    `TNPC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(last_of_run))
    `TNPC_ASSERT_IMP(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
    `TNPC_ASSERT_IMP(a_cfg, clk, rst_n, 1'b1, cfg_ready)
endmodule
bind triangle_near_plane_clip_core tnpc_checker u_chk (.clk, .rst_n, .out_valid, .out_ready,
    .in_ready, .last_of_run, .cfg_ready);
`default_nettype wire
